// ----- rtl/slid_pkg.sv -----
package slid_pkg;

    localparam int CAPACITY  = 16;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CNT_EXT_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] entry_value;
        logic               entry_valid;
        logic               last;
        t_status            status;
        logic [4:0]         count;
    } t_out_res;

    // engine -> output stage
    typedef struct packed {
        logic     valid;
        t_out_res res;
    } t_eng_res;

    // count field is the stored count modulo 32
    function automatic logic [4:0] f_cnt5(logic [CNT_W-1:0] c);
        logic [CNT_EXT_W-1:0] e;
        e = CNT_EXT_W'(c);
        return e[4:0];
    endfunction

endpackage

// ----- rtl/slid_ram.sv -----
module slid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/slid_engine.sv -----
module slid_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  slid_pkg::t_in_req i_req,
    input  logic             i_out_free,
    output logic             o_busy,
    output slid_pkg::t_eng_res o_res
);
    import slid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_DEL,
        S_RD,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_ptr, n_ptr;
    logic [ADDR_W-1:0]   r_last, n_last;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_found, n_found;
    logic signed [31:0]  r_val, n_val;
    t_status             r_status, n_status;

    logic                we, re;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [DATA_W-1:0]   wdata, rdata;
    logic [ADDR_W-1:0]   top_addr;
    logic                hit;

    slid_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign top_addr = ADDR_W'(r_count - 1'b1);
    assign hit      = (rdata == r_val);
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_last   = r_last;
        n_count  = r_count;
        n_found  = r_found;
        n_val    = r_val;
        n_status = r_status;
        we       = 1'b0;
        waddr    = ADDR_W'(r_ptr + 1'b1);
        wdata    = rdata;
        re       = 1'b0;
        raddr    = r_ptr;
        o_res    = '0;
        o_res.res.count = f_cnt5(r_count);

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_val  = i_req.value;
                    n_last = top_addr;
                    case (i_req.cmd)
                        CMD_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                we       = 1'b1;
                                waddr    = '0;
                                wdata    = i_req.value;
                                n_count  = CNT_W'(1);
                                n_status = ST_OK;
                                n_state  = S_DONE;
                            end else begin
                                // walk down from the top entry
                                re      = 1'b1;
                                raddr   = top_addr;
                                n_ptr   = top_addr;
                                n_state = S_INS;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end else begin
                                re      = 1'b1;
                                raddr   = '0;
                                n_ptr   = '0;
                                n_found = 1'b0;
                                n_state = S_DEL;
                            end
                        end
                        CMD_READ: begin
                            n_status = ST_OK;
                            if (r_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                re      = 1'b1;
                                raddr   = '0;
                                n_ptr   = '0;
                                n_state = S_RD;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count  = '0;
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                we = 1'b1;
                if ($signed(rdata) > r_val) begin
                    // move entry up one slot, keep walking down
                    waddr = ADDR_W'(r_ptr + 1'b1);
                    wdata = rdata;
                    if (r_ptr == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        re    = 1'b1;
                        raddr = ADDR_W'(r_ptr - 1'b1);
                        n_ptr = ADDR_W'(r_ptr - 1'b1);
                    end
                end else begin
                    waddr    = ADDR_W'(r_ptr + 1'b1);
                    wdata    = r_val;
                    n_count  = CNT_W'(r_count + 1'b1);
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_INS_LAST: begin
                we       = 1'b1;
                waddr    = '0;
                wdata    = r_val;
                n_count  = CNT_W'(r_count + 1'b1);
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DEL: begin
                // after the match, every entry slides down one slot
                if (r_found) begin
                    we    = 1'b1;
                    waddr = ADDR_W'(r_ptr - 1'b1);
                    wdata = rdata;
                end
                n_found = r_found | hit;
                if (r_ptr == r_last) begin
                    if (n_found) begin
                        n_count  = CNT_W'(r_count - 1'b1);
                        n_status = ST_OK;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    re    = 1'b1;
                    raddr = ADDR_W'(r_ptr + 1'b1);
                    n_ptr = ADDR_W'(r_ptr + 1'b1);
                end
            end
            S_RD: begin
                if (i_out_free) begin
                    o_res.valid           = 1'b1;
                    o_res.res.entry_value = $signed(rdata);
                    o_res.res.entry_valid = 1'b1;
                    o_res.res.last        = (r_ptr == r_last);
                    o_res.res.status      = ST_OK;
                    if (r_ptr == r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        re    = 1'b1;
                        raddr = ADDR_W'(r_ptr + 1'b1);
                        n_ptr = ADDR_W'(r_ptr + 1'b1);
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res.valid      = 1'b1;
                    o_res.res.last   = 1'b1;
                    o_res.res.status = r_status;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
        end
        r_ptr    <= n_ptr;
        r_last   <= n_last;
        r_val    <= n_val;
        r_status <= n_status;
    end
endmodule

// ----- rtl/sorted_list_insert_delete.sv -----
// Sorted store of up to CAPACITY signed 32-bit values, kept ascending in a
// single-port-read / single-port-write RAM.
// Request channel: i_in_valid / o_in_stall carry a command (insert, delete,
// read out, clear) and a value. A request is taken when valid is high and
// stall is low; stall is high for as long as a command is being worked on.
// Result channel: o_out_valid / i_out_stall carry one result per command,
// or one per entry for read out of a non-empty store, the final one flagged by last.
// Steps per command:
//   insert: into an empty store the value is written straight to slot 0;
//           otherwise the RAM walk goes down from the top, moving each larger
//           entry up one slot, then writes the value into the gap;
//   delete: one RAM read per entry, later entries slide down;
//   read out: one result per cycle while the result side does not stall;
//   clear and refused commands: no RAM access, only a status result.
// The registered RAM read and the one read port set the pace of the walks.
// The result sits in an output register, so a new request is taken while
// the last result still waits. A stalled result holds its payload, and a
// read out simply pauses until the receiver takes each entry.
// Reset (synchronous, active low) empties the store; RAM contents are not
// cleared since only entries below the count are ever read.
module sorted_list_insert_delete (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  slid_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output slid_pkg::t_out_res o_out
);
    import slid_pkg::*;

    logic     r_out_valid;
    t_out_res r_out;
    logic     busy;
    logic     out_free;
    logic     req_take;
    t_eng_res eng_res;

    // the output register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    assign req_take = i_in_valid && !busy;

    slid_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(req_take),
        .i_req      (i_in),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_res      (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (eng_res.valid) begin
            r_out <= eng_res.res;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

// ----- rtl/slid_check.sv -----
module slid_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input slid_pkg::t_in_req  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input slid_pkg::t_out_res o_out
);
    import slid_pkg::*;

    // a pending result is not dropped under stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // every taken request makes the block busy in the following cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken without going busy");

    // only read out emits more than one result; every non-final result carries a stored value
    a_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last) |-> o_out.entry_valid)
        else $error("non-final result without a stored value");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.entry_valid) |-> (o_out.entry_value == 32'sd0))
        else $error("entry value not zero outside read out");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_FULL)
            |-> (o_out.count == f_cnt5(CNT_W'(CAPACITY))))
        else $error("full status with store not full");
endmodule

bind sorted_list_insert_delete slid_check u_slid_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in       (i_in),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);
